/* rtl/scp_pkg.sv */
// Shared constants and types for the segment closest-point block.
// This package has no dependencies. Every other file in rtl imports it.
`default_nettype none
package scp_pkg;
	localparam int COORD_BITS  = 14;
	localparam int MARGIN_BITS = 15;
	localparam int DIFF_W      = COORD_BITS + 1;
	localparam int MAG_W       = 2 * DIFF_W + 1;
	localparam int ROOT_W      = (MAG_W + 1) / 2;
	localparam int SQ_W        = 2 * ROOT_W;
	localparam int NUM_W       = MAG_W + 1;
	localparam int DEN_W       = ROOT_W + 1;
	localparam int PROJ_W      = NUM_W + 1;
	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_AW     = 3;

	// One classified item as it waits between the front and the back.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] ay;
		logic signed [DIFF_W-1:0]     dx;
		logic signed [DIFF_W-1:0]     dy;
		logic [MARGIN_BITS-1:0]       m;
		logic [MAG_W-1:0]             mag;
		logic signed [NUM_W-1:0]      dot;
	} job_t;

	// Item riding alongside the projection divider.
	typedef struct packed {
		logic                         vld;
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] ay;
		logic signed [DIFF_W-1:0]     dx;
		logic signed [DIFF_W-1:0]     dy;
		logic [MARGIN_BITS-1:0]       m;
		logic                         neg;
		logic                         degen;
		logic [ROOT_W-1:0]            len;
	} proj_side_t;

	// Item riding alongside the two rounding dividers.
	typedef struct packed {
		logic                         vld;
		logic signed [COORD_BITS-1:0] ax;
		logic signed [COORD_BITS-1:0] ay;
		logic                         neg_x;
		logic                         neg_y;
		logic                         degen;
	} round_side_t;
endpackage
`default_nettype wire

/* rtl/scp_front.sv */
// Front end: takes input transfers, forms differences and products.
// Depends on scp_pkg; writes finished items into scp_fifo.
`default_nettype none
module scp_front import scp_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	input  wire logic signed [COORD_BITS-1:0] query_x,
	input  wire logic signed [COORD_BITS-1:0] query_y,
	input  wire logic [MARGIN_BITS-1:0]       end_margin,
	input  wire logic [FIFO_AW:0]             fifo_count,
	output logic                              push,
	output job_t                              push_data
);
	logic                         v_s1, v_s2;
	logic signed [COORD_BITS-1:0] ax_s1, ay_s1, ax_s2, ay_s2;
	logic signed [DIFF_W-1:0]     dx_s1, dy_s1, qx_s1, qy_s1, dx_s2, dy_s2;
	logic [MARGIN_BITS-1:0]       m_s1, m_s2;
	logic signed [2*DIFF_W-1:0]   sqx_s2, sqy_s2, prx_s2, pry_s2;
	logic [FIFO_AW+1:0]           occupancy;

	// Items still in the two front stages already own a queue slot.
	assign occupancy = (FIFO_AW+2)'(fifo_count) + (FIFO_AW+2)'(v_s1) + (FIFO_AW+2)'(v_s2);
	assign in_stall  = occupancy >= (FIFO_AW+2)'(FIFO_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid && !in_stall;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1  <= start_x;
		ay_s1  <= start_y;
		dx_s1  <= DIFF_W'(end_x) - DIFF_W'(start_x);
		dy_s1  <= DIFF_W'(end_y) - DIFF_W'(start_y);
		qx_s1  <= DIFF_W'(query_x) - DIFF_W'(start_x);
		qy_s1  <= DIFF_W'(query_y) - DIFF_W'(start_y);
		m_s1   <= end_margin;
		ax_s2  <= ax_s1;
		ay_s2  <= ay_s1;
		dx_s2  <= dx_s1;
		dy_s2  <= dy_s1;
		m_s2   <= m_s1;
		sqx_s2 <= dx_s1 * dx_s1;
		sqy_s2 <= dy_s1 * dy_s1;
		prx_s2 <= dx_s1 * qx_s1;
		pry_s2 <= dy_s1 * qy_s1;
	end

	always_comb begin
		push           = v_s2;
		push_data.ax   = ax_s2;
		push_data.ay   = ay_s2;
		push_data.dx   = dx_s2;
		push_data.dy   = dy_s2;
		push_data.m    = m_s2;
		push_data.mag  = MAG_W'($unsigned(sqx_s2)) + MAG_W'($unsigned(sqy_s2));
		push_data.dot  = NUM_W'(prx_s2) + NUM_W'(pry_s2);
	end
endmodule
`default_nettype wire

/* rtl/scp_fifo.sv */
// Short queue between the front end and the back end.
// Depends on scp_pkg for the item type and depth.
`default_nettype none
module scp_fifo import scp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire job_t       push_data,
	input  wire logic       pop,
	output logic            empty,
	output job_t            pop_data,
	output logic [FIFO_AW:0] count
);
	job_t               slots_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_AW:0]   count_q;

	assign empty    = count_q == '0;
	assign pop_data = slots_q[rptr_q];
	assign count    = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			count_q <= count_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wptr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != (FIFO_AW+1)'(FIFO_DEPTH) || pop))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue read while empty");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a write");
endmodule
`default_nettype wire

/* rtl/scp_sqrt.sv */
// Pipelined floor square root, one root bit per stage.
// Depends on scp_pkg for widths.
`default_nettype none
module scp_sqrt import scp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [MAG_W-1:0] radicand,
	output logic [ROOT_W-1:0]     root
);
	logic [SQ_W-1:0]     val_s  [ROOT_W];
	logic [ROOT_W+1:0]   rem_s  [ROOT_W];
	logic [ROOT_W-1:0]   root_s [ROOT_W];
	logic [SQ_W-1:0]     val_n  [ROOT_W];
	logic [ROOT_W+1:0]   rem_n  [ROOT_W];
	logic [ROOT_W-1:0]   root_n [ROOT_W];

	always_comb begin
		logic [SQ_W-1:0]   pv;
		logic [ROOT_W+1:0] pr;
		logic [ROOT_W-1:0] pq;
		logic [ROOT_W+3:0] r, t;
		for (int k = 0; k < ROOT_W; k++) begin
			pv = (k == 0) ? SQ_W'(radicand) : val_s[(k == 0) ? 0 : k-1];
			pr = (k == 0) ? '0 : rem_s[(k == 0) ? 0 : k-1];
			pq = (k == 0) ? '0 : root_s[(k == 0) ? 0 : k-1];
			// Bring down the next two radicand bits and try root*4+1.
			r = {pr, pv[SQ_W-1:SQ_W-2]};
			t = (ROOT_W+4)'({pq, 2'b01});
			val_n[k] = pv << 2;
			if (r >= t) begin
				rem_n[k]  = (ROOT_W+2)'(r - t);
				root_n[k] = {pq[ROOT_W-2:0], 1'b1};
			end else begin
				rem_n[k]  = (ROOT_W+2)'(r);
				root_n[k] = {pq[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < ROOT_W; k++) begin
				val_s[k]  <= val_n[k];
				rem_s[k]  <= rem_n[k];
				root_s[k] <= root_n[k];
			end
		end
	end

	assign root = root_s[ROOT_W-1];
endmodule
`default_nettype wire

/* rtl/scp_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on scp_pkg for widths.
`default_nettype none
module scp_div import scp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] dividend,
	input  wire logic [DEN_W-1:0] divisor,
	output logic [NUM_W-1:0]      quotient
);
	logic [NUM_W-1:0] num_s [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];
	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] quo_s [NUM_W];
	logic [NUM_W-1:0] num_n [NUM_W];
	logic [DEN_W-1:0] den_n [NUM_W];
	logic [DEN_W-1:0] rem_n [NUM_W];
	logic [NUM_W-1:0] quo_n [NUM_W];

	always_comb begin
		logic [NUM_W-1:0] pn, pq;
		logic [DEN_W-1:0] pd, pr;
		logic [DEN_W:0]   r;
		for (int k = 0; k < NUM_W; k++) begin
			pn = (k == 0) ? dividend : num_s[(k == 0) ? 0 : k-1];
			pd = (k == 0) ? divisor  : den_s[(k == 0) ? 0 : k-1];
			pr = (k == 0) ? '0       : rem_s[(k == 0) ? 0 : k-1];
			pq = (k == 0) ? '0       : quo_s[(k == 0) ? 0 : k-1];
			r  = {pr, pn[NUM_W-1]};
			num_n[k] = pn << 1;
			den_n[k] = pd;
			if (r >= (DEN_W+1)'(pd)) begin
				rem_n[k] = DEN_W'(r - (DEN_W+1)'(pd));
				quo_n[k] = {pq[NUM_W-2:0], 1'b1};
			end else begin
				rem_n[k] = DEN_W'(r);
				quo_n[k] = {pq[NUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_W; k++) begin
				num_s[k] <= num_n[k];
				den_s[k] <= den_n[k];
				rem_s[k] <= rem_n[k];
				quo_s[k] <= quo_n[k];
			end
		end
	end

	assign quotient = quo_s[NUM_W-1];
endmodule
`default_nettype wire

/* rtl/segment_closest_point.sv */
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   start_x/y, end_x/y, query_x/y, end_margin
// output    out        out_valid / out_stall near_x, near_y
//
// One transfer per cycle in each direction when neither side stalls.
// Items pass the front stages, the queue, the bit-per-stage square root, the projection
// divider, the margin and scale stages, the two rounding dividers and the output register.
// The back end freezes as a whole while a result waits on out_stall; the eight-entry
// queue keeps taking items until it fills. Reset clears valid bits, queue state and side items.
// Depends on scp_pkg, scp_front, scp_fifo, scp_sqrt and scp_div.
`default_nettype none
module segment_closest_point import scp_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	input  wire logic signed [COORD_BITS-1:0] query_x,
	input  wire logic signed [COORD_BITS-1:0] query_y,
	input  wire logic [MARGIN_BITS-1:0]       end_margin,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [COORD_BITS-1:0]      near_x,
	output logic signed [COORD_BITS-1:0]      near_y
);
	logic             push, pop, empty, en;
	job_t             push_data, pop_data;
	logic [FIFO_AW:0] fifo_count;

	scp_front u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.start_x, .start_y, .end_x, .end_y, .query_x, .query_y, .end_margin,
		.fifo_count, .push, .push_data
	);

	scp_fifo u_fifo (
		.clk, .arst_n, .push, .push_data, .pop, .empty, .pop_data, .count(fifo_count)
	);

	// The whole back end advances unless a finished result is being held.
	assign en  = !(out_valid && out_stall);
	assign pop = en && !empty;

	// Square root of the squared length, with the item riding alongside.
	logic [ROOT_W-1:0] len;
	job_t              sq_job_q [ROOT_W];
	logic              sq_vld_q [ROOT_W];

	scp_sqrt u_sqrt (.clk, .en, .radicand(pop_data.mag), .root(len));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROOT_W; k++)
				sq_vld_q[k] <= 1'b0;
		end else if (en) begin
			sq_vld_q[0] <= pop;
			for (int k = 1; k < ROOT_W; k++)
				sq_vld_q[k] <= sq_vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_job_q[0] <= pop_data;
			for (int k = 1; k < ROOT_W; k++)
				sq_job_q[k] <= sq_job_q[k-1];
		end
	end

	// Projection divide: |dot| / len, sign restored afterwards.
	job_t             sj;
	logic             degen;
	logic [NUM_W-1:0] dot_abs, proj_quo;
	logic [DEN_W-1:0] len_div;
	proj_side_t       pside, pj_q [NUM_W];

	assign sj      = sq_job_q[ROOT_W-1];
	assign degen   = sj.mag <= MAG_W'(1);
	assign dot_abs = sj.dot[NUM_W-1] ? NUM_W'(-sj.dot) : NUM_W'(sj.dot);
	assign len_div = degen ? DEN_W'(1) : DEN_W'(len);

	always_comb begin
		pside.vld   = sq_vld_q[ROOT_W-1];
		pside.ax    = sj.ax;
		pside.ay    = sj.ay;
		pside.dx    = sj.dx;
		pside.dy    = sj.dy;
		pside.m     = sj.m;
		pside.neg   = sj.dot[NUM_W-1];
		pside.degen = degen;
		pside.len   = len;
	end

	scp_div u_div_proj (.clk, .en, .dividend(dot_abs), .divisor(len_div), .quotient(proj_quo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_W; k++)
				pj_q[k] <= '0;
		end else if (en) begin
			pj_q[0] <= pside;
			for (int k = 1; k < NUM_W; k++)
				pj_q[k] <= pj_q[k-1];
		end
	end

	// Margin and clamp stage.
	proj_side_t               pe;
	logic signed [PROJ_W-1:0] q_sgn, l_sgn, m_sgn, p1, p2, pf;
	logic [ROOT_W-1:0]        proj_s3;
	proj_side_t               pe_s3;

	assign pe    = pj_q[NUM_W-1];
	assign q_sgn = pe.neg ? -$signed({1'b0, proj_quo}) : $signed({1'b0, proj_quo});
	assign l_sgn = $signed(PROJ_W'(pe.len));
	assign m_sgn = $signed(PROJ_W'(pe.m));

	always_comb begin
		p1 = (q_sgn < 0) ? '0 : ((q_sgn > l_sgn) ? l_sgn : q_sgn);
		p2 = q_sgn;
		if (pe.m != '0) begin
			if ((m_sgn <<< 1) < l_sgn) begin
				p2 = p1 + m_sgn;
				if (p2 > l_sgn - m_sgn)
					p2 = l_sgn - m_sgn;
				if (p2 < m_sgn)
					p2 = m_sgn;
			end else begin
				p2 = l_sgn >>> 1;
			end
		end
		pf = (p2 < 0) ? '0 : ((p2 > l_sgn) ? l_sgn : p2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pe_s3 <= '0;
		else if (en)
			pe_s3 <= pe;
	end

	always_ff @(posedge clk) begin
		if (en)
			proj_s3 <= ROOT_W'(pf);
	end

	// Scale stage: D * proj, then numerator and denominator for rounding.
	localparam int PROD_W = DIFF_W + ROOT_W + 1;
	logic signed [PROD_W-1:0] prx_s4, pry_s4;
	proj_side_t               pe_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pe_s4 <= '0;
		else if (en)
			pe_s4 <= pe_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prx_s4 <= PROD_W'(pe_s3.dx) * $signed({1'b0, proj_s3});
			pry_s4 <= PROD_W'(pe_s3.dy) * $signed({1'b0, proj_s3});
		end
	end

	logic [NUM_W-1:0] abs_x, abs_y, num_x, num_y, quo_x, quo_y;
	logic [DEN_W-1:0] den_r;
	round_side_t      rside, rd_q [NUM_W];

	assign abs_x = prx_s4[PROD_W-1] ? NUM_W'(-prx_s4) : NUM_W'(prx_s4);
	assign abs_y = pry_s4[PROD_W-1] ? NUM_W'(-pry_s4) : NUM_W'(pry_s4);
	// Rounding half away from zero: (2|n| + len) / (2 len).
	assign num_x = (abs_x << 1) + NUM_W'(pe_s4.len);
	assign num_y = (abs_y << 1) + NUM_W'(pe_s4.len);
	assign den_r = pe_s4.degen ? DEN_W'(2) : {pe_s4.len, 1'b0};

	always_comb begin
		rside.vld   = pe_s4.vld;
		rside.ax    = pe_s4.ax;
		rside.ay    = pe_s4.ay;
		rside.neg_x = prx_s4[PROD_W-1];
		rside.neg_y = pry_s4[PROD_W-1];
		rside.degen = pe_s4.degen;
	end

	scp_div u_div_x (.clk, .en, .dividend(num_x), .divisor(den_r), .quotient(quo_x));
	scp_div u_div_y (.clk, .en, .dividend(num_y), .divisor(den_r), .quotient(quo_y));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_W; k++)
				rd_q[k] <= '0;
		end else if (en) begin
			rd_q[0] <= rside;
			for (int k = 1; k < NUM_W; k++)
				rd_q[k] <= rd_q[k-1];
		end
	end

	// Output register.
	round_side_t                re;
	logic signed [COORD_BITS-1:0] off_x, off_y;
	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] near_x_q, near_y_q;

	assign re    = rd_q[NUM_W-1];
	assign off_x = re.neg_x ? COORD_BITS'(-quo_x) : COORD_BITS'(quo_x);
	assign off_y = re.neg_y ? COORD_BITS'(-quo_y) : COORD_BITS'(quo_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= re.vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			near_x_q <= re.degen ? re.ax : re.ax + off_x;
			near_y_q <= re.degen ? re.ay : re.ay + off_y;
		end
	end

	assign out_valid = out_valid_q;
	assign near_x    = near_x_q;
	assign near_y    = near_y_q;

	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> sq_vld_q[0])
		else $error("queue transfer did not enter the back end");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(rd_q[NUM_W-1]))
		else $error("back end moved while output was held");
	a_no_pop_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !pop)
		else $error("queue read while output was held");
endmodule
`default_nettype wire

/* test/scp_checker.sv */
// Checker for the segment closest-point block: watches both channels,
// predicts each closest point and compares it with the block's output.
// Depends on scp_pkg for the coordinate and margin widths.
`timescale 1ns / 1ps
module scp_checker import scp_pkg::*; (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_stall,
	input wire logic signed [COORD_BITS-1:0] start_x,
	input wire logic signed [COORD_BITS-1:0] start_y,
	input wire logic signed [COORD_BITS-1:0] end_x,
	input wire logic signed [COORD_BITS-1:0] end_y,
	input wire logic signed [COORD_BITS-1:0] query_x,
	input wire logic signed [COORD_BITS-1:0] query_y,
	input wire logic [MARGIN_BITS-1:0]       end_margin,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic signed [COORD_BITS-1:0] near_x,
	input wire logic signed [COORD_BITS-1:0] near_y,
	output int                               fail_count,
	output int                               pending,
	output int                               points_seen
);
	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} point_t;

	point_t expected_points[$];

	function automatic longint isqrt_floor(longint v);
		longint r;
		r = 0;
		while ((r + 1) * (r + 1) <= v)
			r = r + 1;
		return r;
	endfunction

	// Rounds num/den to nearest, ties away from zero; den is positive.
	function automatic longint div_nearest(longint num, longint den);
		longint a, q;
		a = (num < 0) ? -num : num;
		q = (2 * a + den) / (2 * den);
		return (num < 0) ? -q : q;
	endfunction

	function automatic point_t closest_point(longint ax, longint ay, longint bx, longint by,
		longint px, longint py, longint m);
		longint dx, dy, mag, len, proj;
		point_t p;
		dx = bx - ax;
		dy = by - ay;
		mag = dx * dx + dy * dy;
		p.x = COORD_BITS'(ax);
		p.y = COORD_BITS'(ay);
		if (mag > 1) begin
			len = isqrt_floor(mag);
			proj = (dx * (px - ax) + dy * (py - ay)) / len;
			if (m > 0) begin
				if (2 * m < len) begin
					proj = (proj < 0) ? 0 : (proj > len ? len : proj);
					proj = proj + m;
					if (proj > len - m) proj = len - m;
					if (proj < m) proj = m;
				end else begin
					proj = len / 2;
				end
			end
			proj = (proj < 0) ? 0 : (proj > len ? len : proj);
			p.x = COORD_BITS'(ax + div_nearest(dx * proj, len));
			p.y = COORD_BITS'(ay + div_nearest(dy * proj, len));
		end
		return p;
	endfunction

	assign pending = expected_points.size();

	always @(posedge clk or negedge arst_n) begin
		point_t want;
		if (!arst_n) begin
			fail_count <= 0;
			points_seen <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_points.push_back(closest_point(start_x, start_y, end_x, end_y,
					query_x, query_y, end_margin));
			if (out_valid && !out_stall) begin
				points_seen <= points_seen + 1;
				if (expected_points.size() == 0) begin
					$display("%0t: unexpected transfer near=(%0d,%0d)", $time, near_x, near_y);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_points.pop_front();
					if (want.x !== near_x || want.y !== near_y) begin
						$display("%0t: mismatch expected=(%0d,%0d) actual=(%0d,%0d)",
							$time, want.x, want.y, near_x, near_y);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

/* test/tb_top.sv */
// Top of the segment closest-point testbench: clock, reset, stimulus and verdict.
// Depends on scp_pkg, segment_closest_point and scp_checker.
`timescale 1ns / 1ps
module tb_top;
	import scp_pkg::*;

	localparam int RANDOM_ITEMS = 1700;
	localparam int CALM_ITEMS   = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COORD_BITS-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic signed [COORD_BITS-1:0] query_x = '0, query_y = '0;
	logic [MARGIN_BITS-1:0] end_margin = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [COORD_BITS-1:0] near_x, near_y;
	int fail_count, pending, points_seen;
	bit calm = 1'b0;

	always #10 clk = ~clk;

	segment_closest_point dut (.*);

	scp_checker checker_i (.*);

	// Valid stays high from one transfer to the next unless an idle gap is taken.
	task automatic send_segment(int ax, int ay, int bx, int by, int px, int py, int m);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start_x <= COORD_BITS'(ax);
		start_y <= COORD_BITS'(ay);
		end_x <= COORD_BITS'(bx);
		end_y <= COORD_BITS'(by);
		query_x <= COORD_BITS'(px);
		query_y <= COORD_BITS'(py);
		end_margin <= MARGIN_BITS'(m);
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic int rnd_coord(int span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	// Receiver stalls in random bursts; none in the calm tail.
	initial begin
		int burst;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 19);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	initial begin
		int ax, ay, span, m;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: degenerate segments, extremes, margins, queries beyond each end.
		send_segment(5, 5, 5, 5, 100, -100, 0);
		send_segment(5, 5, 6, 5, 100, -100, 0);
		send_segment(5, 5, 6, 6, 100, 100, 0);
		send_segment(-8192, -8192, 8191, 8191, 0, 0, 0);
		send_segment(-8192, -8192, 8191, 8191, -8192, 8191, 0);
		send_segment(8191, -8192, -8192, 8191, 8191, 8191, 32767);
		send_segment(-8192, 8191, 8191, -8192, -8192, -8192, 1);
		send_segment(0, 0, 100, 0, -500, 3, 0);
		send_segment(0, 0, 100, 0, 900, 3, 0);
		send_segment(0, 0, 100, 0, 50, 3, 10);
		send_segment(0, 0, 100, 0, -50, 3, 10);
		send_segment(0, 0, 100, 0, 150, 3, 10);
		send_segment(0, 0, 100, 0, 50, 3, 50);
		send_segment(0, 0, 100, 0, 50, 3, 49);
		send_segment(0, 0, 3, 7, 2, 2, 0);
		send_segment(0, 0, -3, -7, -2, -1, 0);
		send_segment(-8192, 0, 8191, 0, 8191, 8191, 16383);
		send_segment(10, 10, 13, 14, 11, 12, 1);
		send_segment(0, 0, 8191, 8191, 8191, 8191, 0);
		in_valid <= 1'b0;
		@(posedge clk);

		// Pause until every expected point has come back.
		while (pending != 0) @(posedge clk);

		for (int i = 0; i < RANDOM_ITEMS + CALM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS) calm = 1'b1;
			span = ($urandom_range(0, 3) == 0) ? 8192 : $urandom_range(1, 300);
			ax = $urandom_range(0, 16383) - 8192;
			ay = $urandom_range(0, 16383) - 8192;
			case ($urandom_range(0, 3))
				0: m = 0;
				1: m = $urandom_range(0, 32767);
				default: m = $urandom_range(0, span);
			endcase
			send_segment(ax, ay, ax + rnd_coord(span), ay + rnd_coord(span),
				ax + rnd_coord(span), ay + rnd_coord(span), m);
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		$display("Covered %0d closest-point results: degenerate, full-range and short",
			points_seen);
		$display("segments, with and without end margins, under random input gaps and stalls.");
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule
